FILE: rtl/sacl_pkg.sv
// ----------------------------------------------------------------------------
// sacl_pkg
// Types and constants shared by the set-associative cache tag/miss block.
// ----------------------------------------------------------------------------
package sacl_pkg;

  localparam int WAY_COUNT      = 16;
  localparam int SET_INDEX_BITS = 9;
  localparam int OFFSET_BITS    = 5;
  localparam int MISS_SLOTS     = 8;
  localparam int NUM_REQUESTERS = 4;

  localparam int SET_COUNT = 1 << SET_INDEX_BITS;

  localparam int ADDR_W  = 27;
  localparam int REQ_W   = 2;
  localparam int WAY_W   = 4;
  localparam int TAG_W   = ADDR_W - SET_INDEX_BITS;
  localparam int STAMP_W = 32;
  localparam int SLOT_W  = $clog2(MISS_SLOTS);
  localparam int COUNT_W = $clog2(MISS_SLOTS + 1);

  typedef enum logic [1:0] {
    OP_PROBE  = 2'd0,
    OP_INSERT = 2'd1,
    OP_CANCEL = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_STALL     = 3'd1,
    ACT_HIT       = 3'd2,
    ACT_MERGED    = 3'd3,
    ACT_MEM_REQ   = 3'd4,
    ACT_FILL      = 3'd5,
    ACT_DISCARDED = 3'd6,
    ACT_CANCELLED = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [ADDR_W-1:0] block_addr;
    logic [REQ_W-1:0]  requester;
  } req_t;

  typedef struct packed {
    logic [2:0]        action;
    logic [ADDR_W-1:0] out_block_addr;
    logic [REQ_W-1:0]  out_requester;
    logic [WAY_W-1:0]  hit_way;
  } resp_t;

  // One way of a set as held in the set memory.
  typedef struct packed {
    logic               valid;
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } line_t;

  // One set row: every way side by side.
  typedef line_t [WAY_COUNT-1:0] row_t;

endpackage

FILE: rtl/set_assoc_cache_lru_mshr_top.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_mshr_top
// Tag, LRU and miss-register part of a 16-way, 512-set cache.
// ----------------------------------------------------------------------------
// Usage:
//   Present a request word on req and raise start; it is taken at a clock
//   edge where busy is low. busy rises for the following cycle; the set row
//   is read from the set memory into a register at the accepting edge.
//   In the lookup cycle the ways are compared, the victim chosen, the miss
//   registers searched and updated, and the set row written back. The result
//   word appears on resp with done high for exactly one cycle, the cycle
//   after the lookup cycle; the receiver cannot stall it.
//   A new request is not taken during the lookup cycle, because of the
//   read-modify-write of one set row through the single-port set memory.
//   Reset clears the state machine, the LRU clock and the miss registers,
//   then a clearing pass writes every set row to zero, one row a cycle.
//   busy stays high until every row is cleared after reset is released; hold
//   requests until it drops.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_mshr_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  sacl_pkg::req_t   req,
  output logic             busy,
  output logic             done,
  output sacl_pkg::resp_t  resp
);
  import sacl_pkg::*;

  localparam int TREE_N = 1 << $clog2(WAY_COUNT);

  // Set memory: one row holds the valid flag, tag and stamp of every way.
  row_t set_mem [SET_COUNT];
  row_t rd_row;

  state_t state, state_next;
  req_t   cur;
  logic [STAMP_W-1:0] lru_clock;
  logic [MISS_SLOTS-1:0] miss_busy, miss_live;
  logic [ADDR_W-1:0] miss_addr [MISS_SLOTS];
  logic [REQ_W-1:0]  miss_requester [MISS_SLOTS];
  logic [COUNT_W-1:0] miss_in_use;
  logic [SET_INDEX_BITS-1:0] clr_idx;

  logic [SET_INDEX_BITS-1:0] set_idx;
  logic [TAG_W-1:0]          cur_tag;
  assign set_idx = cur.block_addr[SET_INDEX_BITS-1:0];
  assign cur_tag = cur.block_addr[ADDR_W-1:SET_INDEX_BITS];

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);

  // Read on accept, write back in the lookup cycle or during clearing.
  logic                      wr_en;
  logic [SET_INDEX_BITS-1:0] wr_idx;
  row_t                      wr_row;
  always_ff @(posedge clk) begin
    if (wr_en) begin
      set_mem[wr_idx] <= wr_row;
    end
    if (accept) begin
      rd_row <= set_mem[req.block_addr[SET_INDEX_BITS-1:0]];
    end
  end

  // Walk every row once after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (state == ST_CLEAR) begin
      clr_idx <= clr_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clr_idx == SET_INDEX_BITS'(SET_COUNT - 1)) state_next = ST_IDLE;
      ST_IDLE:   if (accept) state_next = ST_LOOKUP;
      ST_LOOKUP: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= req;
    end
  end

  // Lookup datapath.
  line_t lines [WAY_COUNT];
  logic [WAY_COUNT-1:0] hit_vec;
  logic [MISS_SLOTS-1:0] slot_match;
  always_comb begin
    for (int w = 0; w < WAY_COUNT; w++) begin
      lines[w]   = rd_row[w];
      hit_vec[w] = lines[w].valid && (lines[w].tag == cur_tag);
    end
    for (int s = 0; s < MISS_SLOTS; s++) begin
      slot_match[s] = miss_busy[s] && (miss_addr[s] == cur.block_addr)
                      && (miss_requester[s] == cur.requester);
    end
  end

  logic              hit, inv_found, slot_found, free_found;
  logic [WAY_W-1:0]  hit_w, inv_w, old_w;
  logic [SLOT_W-1:0] match_s, free_s;
  always_comb begin
    hit = 1'b0; hit_w = '0;
    inv_found = 1'b0; inv_w = '0;
    for (int w = WAY_COUNT-1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit = 1'b1; hit_w = WAY_W'(w);
      end
      if (!lines[w].valid) begin
        inv_found = 1'b1; inv_w = WAY_W'(w);
      end
    end
    slot_found = 1'b0; match_s = '0;
    free_found = 1'b0; free_s = '0;
    for (int s = MISS_SLOTS-1; s >= 0; s--) begin
      if (slot_match[s]) begin
        slot_found = 1'b1; match_s = SLOT_W'(s);
      end
      if (!miss_busy[s]) begin
        free_found = 1'b1; free_s = SLOT_W'(s);
      end
    end
  end

  // Oldest way by a balanced tree; on a tie keep the left (lower) way.
  logic [STAMP_W-1:0] node_stamp [1:2*TREE_N-1];
  logic [WAY_W-1:0]   node_way   [1:2*TREE_N-1];
  always_comb begin
    for (int n = 0; n < TREE_N; n++) begin
      node_stamp[TREE_N+n] = '1;
      node_way[TREE_N+n]   = '0;
    end
    for (int w = 0; w < WAY_COUNT; w++) begin
      node_stamp[TREE_N+w] = lines[w].stamp;
      node_way[TREE_N+w]   = WAY_W'(w);
    end
    for (int n = TREE_N-1; n >= 1; n--) begin
      if (node_stamp[2*n+1] < node_stamp[2*n]) begin
        node_stamp[n] = node_stamp[2*n+1];
        node_way[n]   = node_way[2*n+1];
      end else begin
        node_stamp[n] = node_stamp[2*n];
        node_way[n]   = node_way[2*n];
      end
    end
    old_w = node_way[1];
  end

  // Decide the update and the result word.
  resp_t              res;
  logic [STAMP_W-1:0] clk_inc;
  logic [WAY_W-1:0]   fill_w;
  assign clk_inc = lru_clock + 1'b1;
  assign fill_w  = hit ? hit_w : (inv_found ? inv_w : old_w);

  always_comb begin
    res.action         = ACT_NONE;
    res.out_block_addr = cur.block_addr;
    res.out_requester  = cur.requester;
    res.hit_way        = '0;
    wr_en  = 1'b0;
    wr_idx = set_idx;
    wr_row = rd_row;
    if (state == ST_CLEAR) begin
      wr_en  = 1'b1;
      wr_idx = clr_idx;
      wr_row = '0;
    end else if (state == ST_LOOKUP) begin
      unique case (op_t'(cur.op))
        OP_PROBE: begin
          if (miss_in_use >= COUNT_W'(MISS_SLOTS)) begin
            res.action = ACT_STALL;
          end else if (hit) begin
            res.action  = ACT_HIT;
            res.hit_way = hit_w;
            wr_en = 1'b1;
            wr_row[hit_w].stamp = clk_inc;
          end else if (slot_found) begin
            res.action = ACT_MERGED;
          end else if (free_found) begin
            res.action = ACT_MEM_REQ;
          end else begin
            res.action = ACT_STALL;
          end
        end
        OP_INSERT: begin
          res.hit_way = fill_w;
          if (!hit) begin
            wr_en = 1'b1;
            wr_row[fill_w] = '{valid: 1'b1, tag: cur_tag, stamp: clk_inc};
          end
          if (slot_found) begin
            res.action = miss_live[match_s] ? ACT_FILL : ACT_DISCARDED;
          end
        end
        OP_CANCEL: begin
          if (slot_found) res.action = ACT_CANCELLED;
        end
        default: begin
          res.out_block_addr = '0;
          res.out_requester  = '0;
        end
      endcase
    end
  end

  // Clock and miss registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      lru_clock   <= '0;
      miss_busy   <= '0;
      miss_live   <= '0;
      miss_in_use <= '0;
    end else if (state == ST_LOOKUP) begin
      unique case (op_t'(cur.op))
        OP_PROBE: begin
          if (miss_in_use < COUNT_W'(MISS_SLOTS)) begin
            lru_clock <= clk_inc;
            if (!hit && !slot_found && free_found) begin
              miss_busy[free_s] <= 1'b1;
              miss_live[free_s] <= 1'b1;
              miss_in_use       <= miss_in_use + 1'b1;
            end
          end
        end
        OP_INSERT: begin
          lru_clock <= clk_inc;
          if (slot_found) begin
            miss_busy[match_s] <= 1'b0;
            miss_live[match_s] <= 1'b0;
            if (miss_in_use != '0) miss_in_use <= miss_in_use - 1'b1;
          end
        end
        OP_CANCEL: begin
          miss_live <= miss_live & ~slot_match;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_LOOKUP && op_t'(cur.op) == OP_PROBE
        && miss_in_use < COUNT_W'(MISS_SLOTS) && !hit && !slot_found && free_found) begin
      miss_addr[free_s]      <= cur.block_addr;
      miss_requester[free_s] <= cur.requester;
    end
  end

  // Register done and the result word; done is a one-cycle strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_LOOKUP);
    end
  end
  always_ff @(posedge clk) begin
    resp <= res;
  end

endmodule
